// ===== hdl/grc_pkg.sv =====
// Shared types, constants and helpers for the grid ray-cast column engine.
// No dependencies; imported by every other file of the block.
package grc_pkg;

  localparam int MAP_SIDE_W  = 7;
  localparam int CELL_ADDR_W = 12;
  localparam int CELL_W      = 4;
  localparam int STEP_W      = 10;
  localparam int POS_W       = 25;
  localparam int NUM_W       = 31;
  localparam int DEN_W       = 26;

  localparam logic [MAP_SIDE_W-1:0]  MAP_MAX_SIDE  = 7'd64;
  localparam logic [CELL_ADDR_W-1:0] CELL_LAST     = 12'd4095;
  localparam logic [STEP_W-1:0]      MAX_STEPS     = 10'd640;
  localparam logic [8:0]             SCREEN_ROWS   = 9'd272;
  // fov*4096/45 == (fov*HALF_RECIP) >> 14, col*fov*256/675 == (col*fov*COLS_RECIP) >> 27
  localparam logic [20:0]            HALF_RECIP    = 21'd1491309;
  localparam logic [25:0]            COLS_RECIP    = 26'd50903317;
  localparam logic [NUM_W-1:0]       HEIGHT_NUM    = 31'd1140850688;
  localparam logic signed [28:0]     NEAR_LIMIT    = 29'sd4194304;
  localparam logic [15:0]            QUARTER_TURN  = 16'd16384;
  localparam logic [16:0]            POLY_A        = 17'd102944;
  localparam logic [16:0]            POLY_B        = 17'd42048;
  localparam logic [16:0]            POLY_C        = 17'd4640;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FOV        = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HALF, ST_COLS, ST_COS, ST_COS_W,
    ST_SIN, ST_SIN_W, ST_MARCH, ST_CORR, ST_CORR_W, ST_DMUL, ST_DCHK, ST_HDIV_W,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {SIN_COS, SIN_SIN, SIN_CORR} sin_sel_t;

  typedef struct packed {
    logic     clr_en;
    logic     cell_we;
    logic     cap;
    logic     div_start;
    logic     sin_start;
    sin_sel_t sin_sel;
    logic     lat_half;
    logic     lat_ray;
    logic     lat_dx;
    logic     lat_dy;
    logic     march_en;
    logic     lat_cosd;
    logic     lat_d;
    logic     hgt_zero;
    logic     hgt_full;
    logic     hgt_div;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic sin_done;
    logic march_done;
    logic march_hit;
    logic d_small;
  } dp_status_t;

  function automatic logic [23:0] palette(input logic [CELL_W-1:0] code);
    logic [23:0] c;
    case (code)
      4'd1:    c = 24'hffffff;
      4'd2:    c = 24'h7acbf5;
      4'd3:    c = 24'heaacb8;
      4'd4:    c = 24'h0000ff;
      4'd5:    c = 24'hff00ff;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/grc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for operand widths.
module grc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [grc_pkg::NUM_W-1:0]  num,
  input  logic [grc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [grc_pkg::NUM_W-1:0]  quo
);
  import grc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== hdl/grc_sine.sv =====
// Polynomial sine over a quantized 16-bit angle, one shared multiplier.
// Depends on grc_pkg for polynomial constants.
module grc_sine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [17:0] sine
);
  import grc_pkg::*;

  logic               busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [14:0]        x_r, x_nxt, x2_r, x2_nxt;
  logic [16:0]        t_r, t_nxt;
  logic signed [17:0] s_r, s_nxt;
  logic [13:0]        a14;
  logic [16:0]        opa;
  logic [14:0]        opb;
  logic [31:0]        prod;
  logic [16:0]        sh;

  always_comb begin
    case (ph_r)
      2'd0:    begin opa = {2'b00, x_r}; opb = x_r;  end
      2'd1:    begin opa = POLY_C;       opb = x2_r; end
      2'd2:    begin opa = t_r;          opb = x2_r; end
      default: begin opa = t_r;          opb = x_r;  end
    endcase
    prod = 32'(opa) * 32'(opb);
    sh   = prod[30:14];
  end

  always_comb begin
    a14      = {angle[13:6], 6'b000000};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    ph_nxt   = ph_r;
    x_nxt    = x_r;
    x2_nxt   = x2_r;
    t_nxt    = t_r;
    s_nxt    = s_r;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 2'd0;
      neg_nxt  = angle[15];
      x_nxt    = angle[14] ? (15'd16384 - {1'b0, a14}) : {1'b0, a14};
    end else if (busy_r) begin
      ph_nxt = ph_r + 2'd1;
      case (ph_r)
        2'd0: x2_nxt = sh[14:0];
        2'd1: t_nxt  = POLY_B - sh;
        2'd2: t_nxt  = POLY_A - sh;
        default: begin
          s_nxt    = neg_r ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    x2_r  <= x2_nxt;
    t_r   <= t_nxt;
    s_r   <= s_nxt;
  end

  assign done = done_r;
  assign sine = s_r;
endmodule

// ===== hdl/grc_dp.sv =====
// Datapath: map memory, config registers, angle setup, ray march, height.
// Depends on grc_pkg, grc_div and grc_sine.
module grc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  grc_pkg::ctrl_cmd_t   cmd,
  output grc_pkg::dp_status_t  status,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [11:0]          in_cell_index,
  input  logic [3:0]           in_cell_value,
  input  logic [8:0]           in_column,
  input  logic [21:0]          in_player_x,
  input  logic [21:0]          in_player_y,
  input  logic [15:0]          in_view_angle,
  output logic [8:0]           out_column,
  output logic                 out_hit,
  output logic [3:0]           out_wall_type,
  output logic [23:0]          out_wall_color,
  output logic [9:0]           out_march_steps,
  output logic [7:0]           out_wall_top,
  output logic [8:0]           out_wall_height
);
  import grc_pkg::*;

  logic [CELL_W-1:0]      mem [0:4095];
  logic [CELL_W-1:0]      rd_r;
  logic [CELL_ADDR_W-1:0] clr_addr_r, mem_addr;
  logic                   mem_we;
  logic [CELL_W-1:0]      mem_wdata;

  logic [6:0]  map_w_r, map_h_r;
  logic [7:0]  fov_r;
  logic [6:0]  w_eff, h_eff;

  logic [8:0]  col_r;
  logic [21:0] px_r, py_r;
  logic [15:0] view_r, half_r, ray_r, sin_angle;

  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [16:0]      colfov, colfov_r;
  logic [28:0]      half_prod;
  logic [42:0]      cols_prod;
  logic             div_done, sin_done;
  logic signed [17:0] sin_s, cosd_r;
  logic [17:0]      sin_mag;
  logic signed [11:0] inc, dx_r, dy_r;

  logic signed [POS_W-1:0] rx_r, ry_r;
  logic [STEP_W-1:0]       i_r, p_i_r, steps_r;
  logic                    pv_r, p_oob_r, p_end_r, hit_r;
  logic [CELL_W-1:0]       code_r;
  logic [8:0]              cx, cy;
  logic                    oob;
  logic [12:0]             rd_addr;
  logic                    stop;

  logic signed [28:0] d_r;
  logic [8:0]         hgt_r;

  assign w_eff = (map_w_r > MAP_MAX_SIDE) ? MAP_MAX_SIDE : map_w_r;
  assign h_eff = (map_h_r > MAP_MAX_SIDE) ? MAP_MAX_SIDE : map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= 7'd16;
      map_h_r <= 7'd16;
      fov_r   <= 8'd60;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_w_r <= cfg_data[6:0];
        REG_MAP_HEIGHT: map_h_r <= cfg_data[6:0];
        REG_FOV:        fov_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // march address
  always_comb begin
    cx      = {1'b0, rx_r[POS_W-2:16]};
    cy      = {1'b0, ry_r[POS_W-2:16]};
    oob     = rx_r[POS_W-1] || ry_r[POS_W-1] || (cx >= {2'b00, w_eff}) ||
              (cy >= {2'b00, h_eff});
    rd_addr = 13'(cy[5:0] * w_eff) + 13'(cx[5:0]);
  end

  always_comb begin
    mem_we    = cmd.clr_en || cmd.cell_we;
    mem_wdata = cmd.clr_en ? '0 : in_cell_value;
    if (cmd.clr_en)       mem_addr = clr_addr_r;
    else if (cmd.cell_we) mem_addr = in_cell_index;
    else                  mem_addr = rd_addr[11:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_en) clr_addr_r <= clr_addr_r + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      col_r  <= in_column;
      px_r   <= in_player_x;
      py_r   <= in_player_y;
      view_r <= in_view_angle;
    end
  end

  // constant divisions by reciprocal multiply
  always_comb begin
    colfov    = 17'(col_r * fov_r);
    half_prod = 29'(fov_r) * HALF_RECIP;
    cols_prod = 43'(colfov_r) * COLS_RECIP;
  end

  assign div_num = HEIGHT_NUM;
  assign div_den = d_r[DEN_W-1:0];

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (cmd.sin_sel)
      SIN_COS:  sin_angle = ray_r + QUARTER_TURN;
      SIN_SIN:  sin_angle = ray_r;
      default:  sin_angle = ray_r - view_r + QUARTER_TURN;
    endcase
  end

  grc_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sin_start),
    .angle (sin_angle),
    .done  (sin_done),
    .sine  (sin_s)
  );

  // truncate toward zero on /64
  always_comb begin
    sin_mag = sin_s[17] ? 18'(-sin_s) : 18'(sin_s);
    inc     = sin_s[17] ? -$signed({1'b0, sin_mag[16:6]}) : $signed({1'b0, sin_mag[16:6]});
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_half) begin
      half_r   <= 16'(half_prod >> 14);
      colfov_r <= colfov;
    end
    if (cmd.lat_ray)  ray_r  <= view_r + 16'(cols_prod >> 27) - half_r;
    if (cmd.lat_dx)   dx_r   <= inc;
    if (cmd.lat_dy)   dy_r   <= inc;
    if (cmd.lat_cosd) cosd_r <= sin_s;
    if (cmd.lat_d)    d_r    <= $signed({1'b0, steps_r}) * cosd_r;
    if (cmd.hgt_zero)      hgt_r <= '0;
    else if (cmd.hgt_full) hgt_r <= SCREEN_ROWS;
    else if (cmd.hgt_div)  hgt_r <= {div_quo[8:1], 1'b0};
  end

  // two-stage march: address/read, then test
  assign stop = pv_r && (p_end_r || p_oob_r || (rd_r != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (cmd.lat_dy) begin
      pv_r <= 1'b0;
    end else if (cmd.march_en) begin
      pv_r <= 1'b1;
    end
    if (cmd.lat_dy) begin
      rx_r <= POS_W'($signed({1'b0, px_r}));
      ry_r <= POS_W'($signed({1'b0, py_r}));
      i_r  <= '0;
    end else if (cmd.march_en) begin
      p_i_r   <= i_r;
      p_end_r <= (i_r == MAX_STEPS);
      p_oob_r <= oob;
      if (i_r != MAX_STEPS) begin
        rx_r <= rx_r + POS_W'(dx_r);
        ry_r <= ry_r + POS_W'(dy_r);
        i_r  <= i_r + 10'd1;
      end
    end
    if (cmd.march_en && stop) begin
      steps_r <= p_i_r;
      hit_r   <= !p_end_r && !p_oob_r;
      code_r  <= (p_end_r || p_oob_r) ? '0 : rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_column      <= col_r;
      out_hit         <= hit_r;
      out_wall_type   <= code_r;
      out_wall_color  <= palette(code_r);
      out_march_steps <= steps_r;
      out_wall_top    <= hit_r ? 8'((SCREEN_ROWS - hgt_r) >> 1) : 8'd0;
      out_wall_height <= hgt_r;
    end
  end

  always_comb begin
    status.clr_last   = (clr_addr_r == CELL_LAST);
    status.div_done   = div_done;
    status.sin_done   = sin_done;
    status.march_done = stop;
    status.march_hit  = !p_end_r && !p_oob_r;
    status.d_small    = (d_r < NEAR_LIMIT);
  end
endmodule

// ===== hdl/grc_ctrl.sv =====
// Controller state machine sequencing clear, setup, march and height steps.
// Depends on grc_pkg for state, command and status types.
module grc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  grc_pkg::dp_status_t status,
  output grc_pkg::ctrl_cmd_t  cmd
);
  import grc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept && in_operation == OP_CAST) state_nxt = ST_HALF;
      ST_HALF:   state_nxt = ST_COLS;
      ST_COLS:   state_nxt = ST_COS;
      ST_COS:    state_nxt = ST_COS_W;
      ST_COS_W:  if (status.sin_done) state_nxt = ST_SIN;
      ST_SIN:    state_nxt = ST_SIN_W;
      ST_SIN_W:  if (status.sin_done) state_nxt = ST_MARCH;
      ST_MARCH: begin
        if (status.march_done) state_nxt = status.march_hit ? ST_CORR : ST_DONE;
      end
      ST_CORR:   state_nxt = ST_CORR_W;
      ST_CORR_W: if (status.sin_done) state_nxt = ST_DMUL;
      ST_DMUL:   state_nxt = ST_DCHK;
      ST_DCHK:   state_nxt = status.d_small ? ST_DONE : ST_HDIV_W;
      ST_HDIV_W: if (status.div_done) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sin_sel   = SIN_COS;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        cmd.cell_we = accept && (in_operation == OP_WRITE);
        cmd.cap     = accept && (in_operation == OP_CAST);
      end
      ST_HALF:   cmd.lat_half = 1'b1;
      ST_COLS:   cmd.lat_ray = 1'b1;
      ST_COS:    cmd.sin_start = 1'b1;
      ST_COS_W:  cmd.lat_dx = status.sin_done;
      ST_SIN: begin
        cmd.sin_sel   = SIN_SIN;
        cmd.sin_start = 1'b1;
      end
      ST_SIN_W: cmd.lat_dy = status.sin_done;
      ST_MARCH: begin
        cmd.march_en = 1'b1;
        cmd.hgt_zero = status.march_done && !status.march_hit;
      end
      ST_CORR: begin
        cmd.sin_sel   = SIN_CORR;
        cmd.sin_start = 1'b1;
      end
      ST_CORR_W: cmd.lat_cosd = status.sin_done;
      ST_DMUL:   cmd.lat_d = 1'b1;
      ST_DCHK: begin
        cmd.hgt_full  = status.d_small;
        cmd.div_start = !status.d_small;
      end
      ST_HDIV_W: cmd.hgt_div = status.div_done;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== hdl/grid_raycast_column.sv =====
// Top level of the grid ray-cast column engine.
// Depends on grc_pkg, grc_ctrl and grc_dp.
// After reset the map store is swept to zero, all 4096 cells; in_ready stays low
// meanwhile, config writes are taken at once. A map-cell write leaves the block idle.
// A cast runs one item at a time: the half-field and column angle terms, two sine
// evaluations, then one march step per cycle (up to 640 steps, with the stopping
// position tested behind the map-read stage), then on a hit a sine, a multiply,
// a check and a height division, which is skipped for full height when the wall
// is within one cell. The march loop over the map memory takes most of a cast.
// The result sits in an output register, and the next item is taken once it is
// loaded there.
module grid_raycast_column (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [11:0] in_cell_index,
  input  logic [3:0]  in_cell_value,
  input  logic [8:0]  in_column,
  input  logic [21:0] in_player_x,
  input  logic [21:0] in_player_y,
  input  logic [15:0] in_view_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_column,
  output logic        out_hit,
  output logic [3:0]  out_wall_type,
  output logic [23:0] out_wall_color,
  output logic [9:0]  out_march_steps,
  output logic [7:0]  out_wall_top,
  output logic [8:0]  out_wall_height
);
  import grc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .cmd          (cmd)
  );

  grc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cell_index   (in_cell_index),
    .in_cell_value   (in_cell_value),
    .in_column       (in_column),
    .in_player_x     (in_player_x),
    .in_player_y     (in_player_y),
    .in_view_angle   (in_view_angle),
    .out_column      (out_column),
    .out_hit         (out_hit),
    .out_wall_type   (out_wall_type),
    .out_wall_color  (out_wall_color),
    .out_march_steps (out_march_steps),
    .out_wall_top    (out_wall_top),
    .out_wall_height (out_wall_height)
  );
endmodule

// ===== dv/tb.sv =====
// Testbench for grid_raycast_column: map writes and column casts checked against a
// built-in predictor, under random idle/stall phases and several register settings.
// Depends on grc_pkg and the grid_raycast_column RTL.
`timescale 1ns / 1ps

import grc_pkg::*;

typedef struct {
  bit [8:0]  column;
  bit        hit;
  bit [3:0]  wall_type;
  bit [23:0] wall_color;
  bit [9:0]  march_steps;
  bit [7:0]  wall_top;
  bit [8:0]  wall_height;
} cast_result_t;

class raycast_scoreboard;
  bit [3:0] cells [4096];
  bit [6:0] map_w = 16;
  bit [6:0] map_h = 16;
  bit [7:0] fov = 60;
  cast_result_t pending [$];
  int errors = 0;

  function void set_reg(bit [1:0] idx, bit [7:0] v);
    case (idx)
      REG_MAP_WIDTH:  map_w = v[6:0];
      REG_MAP_HEIGHT: map_h = v[6:0];
      REG_FOV:        fov = v;
      default: ;
    endcase
  endfunction

  function int sine_q16(bit [31:0] ang);
    longint unsigned a, x, x2, t, s;
    a = {ang[15:6], 6'b0};
    x = a[13:0];
    if (a[14]) x = 16384 - x;
    x2 = (x * x) >> 14;
    t = 42048 - ((4640 * x2) >> 14);
    t = 102944 - ((t * x2) >> 14);
    s = (t * x) >> 14;
    return a[15] ? -int'(s) : int'(s);
  endfunction

  function bit [23:0] wall_rgb(bit [3:0] code);
    case (code)
      4'd1: return 24'hffffff;
      4'd2: return 24'h7acbf5;
      4'd3: return 24'heaacb8;
      4'd4: return 24'h0000ff;
      4'd5: return 24'hff00ff;
      default: return 24'h000000;
    endcase
  endfunction

  function void note_item(bit op, bit [11:0] idx, bit [3:0] val, bit [8:0] col,
                          bit [21:0] px, bit [21:0] py, bit [15:0] view);
    cast_result_t r;
    int w, h, steps, height;
    longint half, colstep, dx, dy, rx, ry, d, cosd;
    bit [15:0] ray, diff;
    bit [3:0] code;
    bit found;
    if (op == OP_WRITE) begin
      cells[idx] = val;
      return;
    end
    w = (map_w > 64) ? 64 : map_w;
    h = (map_h > 64) ? 64 : map_h;
    half = longint'(fov) * 65536 / 720;
    colstep = longint'(col) * longint'(fov) * 65536 / 172800;
    ray = 16'(longint'(view) + colstep - half);
    dx = sine_q16(32'(ray) + 32'd16384) / 64;
    dy = sine_q16(32'(ray)) / 64;
    steps = MAX_STEPS;
    code = 0;
    found = 0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      rx = longint'(px) + i * dx;
      ry = longint'(py) + i * dy;
      if (rx < 0 || ry < 0 || (rx >> 16) >= w || (ry >> 16) >= h) begin
        steps = i;
        break;
      end
      code = cells[((ry >> 16) * w + (rx >> 16)) % 4096];
      if (code != 0) begin
        found = 1;
        steps = i;
        break;
      end
    end
    height = 0;
    if (found) begin
      diff = ray - view;
      cosd = sine_q16(32'(diff) + 32'd16384);
      d = steps * cosd;
      height = (d < 4194304) ? 272 : int'(64'd1140850688 / d);
      height = height & ~1;
    end else begin
      code = 0;
    end
    r.column = col;
    r.hit = found;
    r.wall_type = code;
    r.wall_color = wall_rgb(code);
    r.march_steps = 10'(steps);
    r.wall_height = 9'(height);
    r.wall_top = found ? 8'((272 - height) / 2) : 8'd0;
    pending.push_back(r);
  endfunction

  function void check_result(cast_result_t got);
    cast_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result for column %0d", got.column);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.column != e.column) begin
      $error("out_column exp %0d got %0d", e.column, got.column); errors++;
    end
    if (got.hit != e.hit) begin
      $error("out_hit exp %0d got %0d", e.hit, got.hit); errors++;
    end
    if (got.wall_type != e.wall_type) begin
      $error("out_wall_type exp %0d got %0d", e.wall_type, got.wall_type); errors++;
    end
    if (got.wall_color != e.wall_color) begin
      $error("out_wall_color exp %0h got %0h", e.wall_color, got.wall_color); errors++;
    end
    if (got.march_steps != e.march_steps) begin
      $error("out_march_steps exp %0d got %0d", e.march_steps, got.march_steps); errors++;
    end
    if (got.wall_top != e.wall_top) begin
      $error("out_wall_top exp %0d got %0d", e.wall_top, got.wall_top); errors++;
    end
    if (got.wall_height != e.wall_height) begin
      $error("out_wall_height exp %0d got %0d", e.wall_height, got.wall_height); errors++;
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [7:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_operation = 0;
  logic [11:0] in_cell_index = 0;
  logic [3:0]  in_cell_value = 0;
  logic [8:0]  in_column = 0;
  logic [21:0] in_player_x = 0;
  logic [21:0] in_player_y = 0;
  logic [15:0] in_view_angle = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [8:0]  out_column;
  logic        out_hit;
  logic [3:0]  out_wall_type;
  logic [23:0] out_wall_color;
  logic [9:0]  out_march_steps;
  logic [7:0]  out_wall_top;
  logic [8:0]  out_wall_height;

  raycast_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;

  grid_raycast_column uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cast_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.column = out_column;
      got.hit = out_hit;
      got.wall_type = out_wall_type;
      got.wall_color = out_wall_color;
      got.march_steps = out_march_steps;
      got.wall_top = out_wall_top;
      got.wall_height = out_wall_height;
      sb.check_result(got);
    end
  end

  task automatic send_item(bit op, bit [11:0] idx, bit [3:0] val, bit [8:0] col,
                           bit [21:0] px, bit [21:0] py, bit [15:0] view);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_cell_index <= idx;
    in_cell_value <= val;
    in_column <= col;
    in_player_x <= px;
    in_player_y <= py;
    in_view_angle <= view;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, idx, val, col, px, py, view);
    @(negedge clk);
  endtask

  task automatic write_cell(int idx, bit [3:0] val);
    send_item(OP_WRITE, 12'(idx), val, 9'($urandom), 22'($urandom), 22'($urandom),
              16'($urandom));
  endtask

  task automatic cast(bit [8:0] col, bit [21:0] px, bit [21:0] py, bit [15:0] view);
    send_item(OP_CAST, 12'($urandom), 4'($urandom), col, px, py, view);
  endtask

  // block goes quiet: all results in, then a settling wait for any trailing write
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [7:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic build_walls(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (r == 0 || c == 0 || r == h - 1 || c == w - 1)
          write_cell(r * w + c, 4'($urandom_range(1, 15)));
    for (int k = 0; k < 6 && w > 2 && h > 2; k++)
      write_cell($urandom_range(1, h - 2) * w + $urandom_range(1, w - 2),
                 4'($urandom_range(0, 15)));
  endtask

  int widths [7]  = '{16, 64, 1, 127, 8, 0, 40};
  int heights [7] = '{16, 64, 1, 100, 8, 5, 24};
  int fovs [7]    = '{60, 179, 1, 255, 90, 0, 120};

  initial begin
    int w, h;
    bit [21:0] px, py;
    repeat (9) @(negedge clk);
    rst_n <= 1;

    // directed: 16x16 room at reset settings
    for (int i = 0; i < 16; i++) begin
      write_cell(i, 4'((i % 9) + 1));
      write_cell(240 + i, 4'((i % 6) + 10));
    end
    write_cell(16 * 8, 9);
    write_cell(16 * 8 + 15, 5);
    write_cell(4095, 15);
    cast(0, 22'd557056, 22'd557056, 16'd0);
    cast(479, 22'd557056, 22'd557056, 16'd16384);
    cast(240, 22'd557056, 22'd557056, 16'd32768);
    cast(511, 22'd557056, 22'd557056, 16'd49152);
    cast(100, 22'd557056, 22'd557056, 16'd65535);
    cast(7, 22'd0, 22'd0, 16'd8192);
    cast(300, 22'h3fffff, 22'h3fffff, 16'd0);
    cast(240, 22'd524288, 22'd524288, 16'd24576);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      write_reg(REG_MAP_WIDTH, 8'(widths[p]));
      write_reg(REG_MAP_HEIGHT, 8'(heights[p]));
      write_reg(REG_FOV, 8'(fovs[p]));
      w = widths[p] > 64 ? 64 : widths[p];
      h = heights[p] > 64 ? 64 : heights[p];
      build_walls(w, h);
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(9) == 0 || w < 3 || h < 3) begin
          if ($urandom_range(3) == 0)
            write_cell($urandom, 4'($urandom));
          else
            cast(9'($urandom), 22'($urandom), 22'($urandom), 16'($urandom));
        end else begin
          px = 22'($urandom_range(65536, (w - 1) * 65536 - 1));
          py = 22'($urandom_range(65536, (h - 1) * 65536 - 1));
          cast(9'($urandom_range(0, 479)), px, py, 16'($urandom));
        end
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== grid_raycast_column.f =====
hdl/grc_pkg.sv
hdl/grc_div.sv
hdl/grc_sine.sv
hdl/grc_dp.sv
hdl/grc_ctrl.sv
hdl/grid_raycast_column.sv
dv/tb.sv
